@@ rtl/core/bfsp_pkg.sv @@
// Shared types, constants and state codes for the Bellman-Ford shortest path block.
// No dependencies; every other file of the block but bfsp_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bfsp_pkg;

	// fixed field widths
	localparam int NODE_BITS   = 7;
	localparam int WEIGHT_BITS = 16;
	localparam int DIST_BITS   = 32;

	// defaults for the top-level parameters
	localparam int MAX_NODES_DEF = 64;
	localparam int MAX_EDGES_DEF = 1024;

	// configuration register indexes and reset values
	localparam logic CFG_NODE_COUNT  = 1'b0;
	localparam logic CFG_SOURCE_NODE = 1'b1;
	localparam logic [NODE_BITS-1:0] NODE_COUNT_RESET  = 7'd64;
	localparam logic [NODE_BITS-1:0] SOURCE_NODE_RESET = 7'd1;

	// saturation limits
	localparam logic signed [DIST_BITS-1:0] DIST_MAX = {1'b0, {(DIST_BITS-1){1'b1}}};
	localparam logic signed [DIST_BITS-1:0] DIST_MIN = {1'b1, {(DIST_BITS-1){1'b0}}};

	// one edge request
	typedef struct packed {
		logic [NODE_BITS-1:0]          edge_from;
		logic [NODE_BITS-1:0]          edge_to;
		logic signed [WEIGHT_BITS-1:0] edge_weight;
		logic                          last_edge;
	} edge_req_t;

	// one stored edge
	typedef struct packed {
		logic [NODE_BITS-1:0]          edge_from;
		logic [NODE_BITS-1:0]          edge_to;
		logic signed [WEIGHT_BITS-1:0] edge_weight;
	} edge_rec_t;

	// one result per node
	typedef struct packed {
		logic [NODE_BITS-1:0]        node_index;
		logic signed [DIST_BITS-1:0] distance;
		logic                        reachable;
		logic                        edges_dropped;
		logic                        last_node;
	} result_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_EREAD,
		ST_LOOKUP,
		ST_RELAX,
		ST_EMIT
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic store;
		logic init;
		logic lookup;
		logic relax;
		logic emit;
		logic finish;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic edges_empty;
		logic edge_last;
		logic round_last;
		logic emit_last;
	} status_t;

endpackage

`default_nettype wire

@@ rtl/core/bfsp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bfsp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/core/bfsp_ctrl.sv @@
// Controller state machine: edge loading, initialisation, relaxation sweep and emission.
// Depends on bfsp_pkg for state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module bfsp_ctrl
	import bfsp_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire logic    last_edge,
	input  wire status_t status,
	output cmd_t         cmd,
	output logic         busy
);

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign accept = start && (state_q == ST_IDLE);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && last_edge) state_d = ST_INIT;
			end
			ST_INIT: begin
				state_d = status.edges_empty ? ST_EMIT : ST_EREAD;
			end
			ST_EREAD:  state_d = ST_LOOKUP;
			ST_LOOKUP: state_d = ST_RELAX;
			ST_RELAX: begin
				if (status.edge_last && status.round_last) state_d = ST_EMIT;
				else state_d = ST_EREAD;
			end
			ST_EMIT: begin
				if (status.emit_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy      = 1'b0;
				cmd.store = accept;
			end
			ST_INIT:   cmd.init   = 1'b1;
			ST_EREAD:  cmd        = '0;
			ST_LOOKUP: cmd.lookup = 1'b1;
			ST_RELAX:  cmd.relax  = 1'b1;
			ST_EMIT: begin
				cmd.emit   = 1'b1;
				cmd.finish = status.emit_last;
			end
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/core/bfsp_dpath.sv @@
// Datapath: configuration registers, edge and distance memories, counters,
// saturating relaxation and the result register. Depends on bfsp_pkg and bfsp_ram.
`timescale 1ns / 1ps
`default_nettype none

module bfsp_dpath
	import bfsp_pkg::*;
#(
	parameter int MAX_NODES = MAX_NODES_DEF,
	parameter int MAX_EDGES = MAX_EDGES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_index,
	input  wire logic [NODE_BITS-1:0] cfg_data,
	input  wire edge_req_t            edge_item,
	input  wire cmd_t                 cmd,
	output status_t                   status,
	output result_t                   result,
	output logic                      result_valid
);

	localparam int ETW = $clog2(MAX_EDGES + 1);
	localparam int AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int NAW = $clog2(MAX_NODES);
	localparam int RECW = $bits(edge_rec_t);
	localparam logic [NODE_BITS-1:0] MAXN = NODE_BITS'(MAX_NODES);
	localparam logic [ETW-1:0]       MAXE = ETW'(MAX_EDGES);

	logic [NODE_BITS-1:0] node_count_q, source_q, count_q, round_q, k_q;
	logic [NODE_BITS-1:0] count_c, u_m1, v_m1, s_m1, k_next;
	logic [ETW-1:0]       edge_total_q, e_q, e_next;
	logic                 overflow_q, full;
	logic [MAX_NODES-1:0] valid_q;

	edge_rec_t            wrec, rrec;
	logic [RECW-1:0]      rrec_bits;
	logic [NAW-1:0]       ui_c, vi_c, src_idx, ui_q, vi_q, raddr_a;
	logic                 ok_c, ok_q, src_ok;
	logic signed [WEIGHT_BITS-1:0] w_q;

	logic signed [DIST_BITS-1:0] dist_u, dist_v, cand;
	logic signed [DIST_BITS:0]   sum;
	logic                        improve;
	logic                        dwe;
	logic [NAW-1:0]              dwaddr;
	logic signed [DIST_BITS-1:0] dwdata;

	logic                        valid_s1, reach_s1, drop_s1, last_s1;
	logic [NODE_BITS-1:0]        index_s1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RESET;
			source_q     <= SOURCE_NODE_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_NODE_COUNT) node_count_q <= cfg_data;
			else source_q <= cfg_data;
		end
	end

	// clamped node count and source check
	always_comb begin
		if (node_count_q == '0) count_c = NODE_BITS'(1);
		else if (node_count_q > MAXN) count_c = MAXN;
		else count_c = node_count_q;
		src_ok  = (source_q != '0) && (source_q <= count_c);
		s_m1    = source_q - NODE_BITS'(1);
		src_idx = s_m1[NAW-1:0];
	end

	// edge memory
	assign full = (edge_total_q == MAXE);
	always_comb begin
		wrec.edge_from   = edge_item.edge_from;
		wrec.edge_to     = edge_item.edge_to;
		wrec.edge_weight = edge_item.edge_weight;
	end

	bfsp_ram #(.WIDTH(RECW), .DEPTH(MAX_EDGES)) u_edge_ram (
		.clk   (clk),
		.we    (cmd.store && !full),
		.waddr (edge_total_q[AW-1:0]),
		.wdata (wrec),
		.raddr (e_q[AW-1:0]),
		.rdata (rrec_bits)
	);
	assign rrec = edge_rec_t'(rrec_bits);

	// edge count and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_total_q <= '0;
			overflow_q   <= 1'b0;
		end else if (cmd.finish) begin
			edge_total_q <= '0;
			overflow_q   <= 1'b0;
		end else if (cmd.store) begin
			if (full) overflow_q <= 1'b1;
			else edge_total_q <= edge_total_q + ETW'(1);
		end
	end

	// endpoint check and distance read addresses
	always_comb begin
		u_m1 = rrec.edge_from - NODE_BITS'(1);
		v_m1 = rrec.edge_to - NODE_BITS'(1);
		ui_c = u_m1[NAW-1:0];
		vi_c = v_m1[NAW-1:0];
		ok_c = (rrec.edge_from != '0) && (rrec.edge_from <= count_q)
			&& (rrec.edge_to != '0) && (rrec.edge_to <= count_q);
		raddr_a = cmd.emit ? k_q[NAW-1:0] : ui_c;
	end

	// latched edge under relaxation
	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			ui_q <= ui_c;
			vi_q <= vi_c;
			w_q  <= rrec.edge_weight;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q <= 1'b0;
		end else if (cmd.lookup) begin
			ok_q <= ok_c;
		end
	end

	// saturating candidate and improvement test
	always_comb begin
		sum = {dist_u[DIST_BITS-1], dist_u}
			+ (DIST_BITS+1)'(w_q);
		if (sum[DIST_BITS] != sum[DIST_BITS-1]) cand = sum[DIST_BITS] ? DIST_MIN : DIST_MAX;
		else cand = sum[DIST_BITS-1:0];
		improve = cmd.relax && ok_q && valid_q[ui_q]
			&& (!valid_q[vi_q] || (dist_v > cand));
	end

	// distance memory write: source seed or relaxed head
	always_comb begin
		if (cmd.init) begin
			dwe    = src_ok;
			dwaddr = src_idx;
			dwdata = '0;
		end else begin
			dwe    = improve;
			dwaddr = vi_q;
			dwdata = cand;
		end
	end

	// two copies so tail and head read together
	bfsp_ram #(.WIDTH(DIST_BITS), .DEPTH(MAX_NODES)) u_dist_a (
		.clk   (clk),
		.we    (dwe),
		.waddr (dwaddr),
		.wdata (dwdata),
		.raddr (raddr_a),
		.rdata (dist_u)
	);

	bfsp_ram #(.WIDTH(DIST_BITS), .DEPTH(MAX_NODES)) u_dist_b (
		.clk   (clk),
		.we    (dwe),
		.waddr (dwaddr),
		.wdata (dwdata),
		.raddr (vi_c),
		.rdata (dist_v)
	);

	// reachable flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.init) begin
			valid_q <= src_ok ? ({{(MAX_NODES-1){1'b0}}, 1'b1} << src_idx) : '0;
		end else if (improve) begin
			valid_q[vi_q] <= 1'b1;
		end
	end

	// sweep counters
	assign e_next = e_q + ETW'(1);
	assign k_next = k_q + NODE_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= NODE_BITS'(1);
			round_q <= '0;
			e_q     <= '0;
			k_q     <= '0;
		end else if (cmd.init) begin
			count_q <= count_c;
			round_q <= '0;
			e_q     <= '0;
			k_q     <= '0;
		end else begin
			if (cmd.relax) begin
				if (status.edge_last) begin
					e_q     <= '0;
					round_q <= round_q + NODE_BITS'(1);
				end else begin
					e_q <= e_next;
				end
			end
			if (cmd.emit) k_q <= k_next;
		end
	end

	always_comb begin
		status.edges_empty = (edge_total_q == '0);
		status.edge_last   = (e_next == edge_total_q);
		status.round_last  = ((round_q + NODE_BITS'(1)) == count_q);
		status.emit_last   = (k_next == count_q);
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			index_s1 <= k_next;
			reach_s1 <= valid_q[k_q[NAW-1:0]];
			drop_s1  <= overflow_q;
			last_s1  <= status.emit_last;
		end
	end

	assign result_valid         = valid_s1;
	assign result.node_index    = index_s1;
	assign result.distance      = reach_s1 ? dist_u : '0;
	assign result.reachable     = reach_s1;
	assign result.edges_dropped = drop_s1;
	assign result.last_node     = last_s1;

`ifndef SYNTHESIS
	// edge count never passes capacity
	assert property (@(posedge clk) disable iff (!arst_n) edge_total_q <= MAXE)
		else $error("edge count beyond capacity");

	// an accepted relaxation leaves the head reachable
	assert property (@(posedge clk) disable iff (!arst_n) improve |=> valid_q[vi_q])
		else $error("relaxed node not marked reachable");

	// a valid source is reachable right after initialisation
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.init && src_ok) |=> valid_q[src_idx])
		else $error("source not seeded");

	// the sweep never runs more rounds than nodes in use
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.relax || cmd.lookup) |-> (round_q < count_q))
		else $error("round counter overran");
`endif

endmodule

`default_nettype wire

@@ rtl/core/bellman_ford_shortest_path.sv @@
// Bellman-Ford shortest path engine: an edge request is taken when start is high and busy
// low; after the last edge: an init state, then count relaxation rounds over all edges
// (one edge memory read, one distance lookup, one relax per edge), then one result per
// cycle, count results in all, the first in the cycle after emission starts; busy drops
// with the last result. Results cannot be stalled. Reset clears control state and sets
// node_count to 64 and source_node to 1; the memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module bellman_ford_shortest_path
	import bfsp_pkg::*;
#(
	parameter int MAX_NODES = MAX_NODES_DEF,
	parameter int MAX_EDGES = MAX_EDGES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire edge_req_t            edge_item,
	output result_t                   result,
	output logic                      result_valid,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_index,
	input  wire logic [NODE_BITS-1:0] cfg_data
);

	cmd_t    cmd;
	status_t status;

	// sequencer
	bfsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.last_edge (edge_item.last_edge),
		.status    (status),
		.cmd       (cmd),
		.busy      (busy)
	);

	// storage and arithmetic
	bfsp_dpath #(
		.MAX_NODES (MAX_NODES),
		.MAX_EDGES (MAX_EDGES)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.edge_item    (edge_item),
		.cmd          (cmd),
		.status       (status),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule

`default_nettype wire
